>>> design/hdmsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdmsc_pkg
// Shared types, codes and default sizes for the hashed direct-mapped cache.
// ----------------------------------------------------------------------------
package hdmsc_pkg;

    localparam int INDEX_BITS_DEF = 10;
    localparam int KEY_WIDTH_DEF  = 64;
    localparam int HASH_W         = 64;
    localparam int ACT_W          = 3;
    localparam int CNT_W          = 32;
    localparam int QUEUE_DEPTH    = 2;

    // request codes as they arrive on the input port
    localparam logic [ACT_W-1:0] ACT_TEST       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TRY_INSERT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TEST_INS   = 3'd4;

    // decoded operation carried through the queue
    typedef enum logic [2:0] {
        OP_TEST,
        OP_INSERT,
        OP_REMOVE,
        OP_TRY_INSERT,
        OP_TEST_INS,
        OP_NOP
    } t_op;

    localparam int OP_W = $bits(t_op);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

endpackage

>>> design/hdmsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdmsc_front
// Decodes the request code and packs a transaction for the queue.
// ----------------------------------------------------------------------------
module hdmsc_front #(
    parameter int KEY_WIDTH = hdmsc_pkg::KEY_WIDTH_DEF,
    parameter int ENTRY_W   = hdmsc_pkg::OP_W + hdmsc_pkg::HASH_W + KEY_WIDTH
) (
    input  logic [hdmsc_pkg::ACT_W-1:0]  i_action,
    input  logic [hdmsc_pkg::HASH_W-1:0] i_hash_value,
    input  logic [KEY_WIDTH-1:0]         i_element_key,
    output logic [ENTRY_W-1:0]           o_entry
);

    hdmsc_pkg::t_op op;

    always_comb begin
        unique case (i_action)
            hdmsc_pkg::ACT_TEST:       op = hdmsc_pkg::OP_TEST;
            hdmsc_pkg::ACT_INSERT:     op = hdmsc_pkg::OP_INSERT;
            hdmsc_pkg::ACT_REMOVE:     op = hdmsc_pkg::OP_REMOVE;
            hdmsc_pkg::ACT_TRY_INSERT: op = hdmsc_pkg::OP_TRY_INSERT;
            hdmsc_pkg::ACT_TEST_INS:   op = hdmsc_pkg::OP_TEST_INS;
            default:                   op = hdmsc_pkg::OP_NOP;
        endcase
    end

    assign o_entry = {op, i_hash_value, i_element_key};

endmodule

>>> design/hdmsc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdmsc_queue
// Short register queue between the decode side and the table side.
// ----------------------------------------------------------------------------
module hdmsc_queue #(
    parameter int ENTRY_W = hdmsc_pkg::OP_W + hdmsc_pkg::HASH_W + hdmsc_pkg::KEY_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [ENTRY_W-1:0] i_push_data,
    input  logic               i_pop,
    output logic [ENTRY_W-1:0] o_pop_data,
    output logic               o_full,
    output logic               o_empty
);

    localparam int PTR_W = (hdmsc_pkg::QUEUE_DEPTH > 1) ? $clog2(hdmsc_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(hdmsc_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(hdmsc_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(hdmsc_pkg::QUEUE_DEPTH);

    logic [ENTRY_W-1:0] r_slot [hdmsc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;

    assign o_full     = (r_count == FULL_CNT);
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> design/hdmsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdmsc_back
// Table side: clears the slot memory after reset, then runs one
// read-modify-write per transaction and keeps the two saturating counters.
// ----------------------------------------------------------------------------
module hdmsc_back #(
    parameter int INDEX_BITS = hdmsc_pkg::INDEX_BITS_DEF,
    parameter int KEY_WIDTH  = hdmsc_pkg::KEY_WIDTH_DEF,
    parameter int ENTRY_W    = hdmsc_pkg::OP_W + hdmsc_pkg::HASH_W + KEY_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  logic [ENTRY_W-1:0]          i_q_data,
    output logic                        o_q_pop,
    output logic                        o_clearing,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic                        o_hit,
    output logic [hdmsc_pkg::CNT_W-1:0] o_slots_used,
    output logic [hdmsc_pkg::CNT_W-1:0] o_miss_count
);

    localparam int DEPTH  = 1 << INDEX_BITS;
    localparam int HASH_W = hdmsc_pkg::HASH_W;
    localparam int CNT_W  = hdmsc_pkg::CNT_W;

    logic [HASH_W-1:0]    r_mem_hash [DEPTH];
    logic [KEY_WIDTH-1:0] r_mem_key  [DEPTH];

    hdmsc_pkg::t_state r_state, n_state;

    hdmsc_pkg::t_op       r_cur_op;
    logic [HASH_W-1:0]    r_cur_hash;
    logic [KEY_WIDTH-1:0] r_cur_key;
    logic [HASH_W-1:0]    r_rd_hash;
    logic [KEY_WIDTH-1:0] r_rd_key;

    logic [INDEX_BITS-1:0] r_clr_idx, n_clr_idx;
    logic [CNT_W-1:0]      r_fill, n_fill;
    logic [CNT_W-1:0]      r_miss, n_miss;
    logic                  r_out_valid, n_out_valid;
    logic                  r_hit, n_hit;

    logic [INDEX_BITS-1:0] cur_idx;
    logic                  out_free;
    logic                  exec_go;
    logic                  slot_empty, hash_eq, key_eq;
    logic                  op_hit, fill_inc, miss_inc;
    logic                  op_we_hash, op_we_key, op_clr_hash;

    logic                  we_hash, we_key;
    logic [INDEX_BITS-1:0] waddr;
    logic [HASH_W-1:0]     wd_hash;
    logic [KEY_WIDTH-1:0]  wd_key;

    assign cur_idx  = r_cur_hash[INDEX_BITS-1:0];
    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hdmsc_pkg::ST_CLEAR: if (r_clr_idx == '1) n_state = hdmsc_pkg::ST_IDLE;
            hdmsc_pkg::ST_IDLE:  if (!i_q_empty) n_state = hdmsc_pkg::ST_READ;
            hdmsc_pkg::ST_READ:  n_state = hdmsc_pkg::ST_EXEC;
            hdmsc_pkg::ST_EXEC:  if (out_free) n_state = hdmsc_pkg::ST_IDLE;
            default:             n_state = hdmsc_pkg::ST_CLEAR;
        endcase
    end

    // per-operation decision on the slot read back
    always_comb begin
        slot_empty  = (r_rd_hash == '0);
        hash_eq     = (r_rd_hash == r_cur_hash);
        key_eq      = (r_rd_key == r_cur_key);
        op_hit      = 1'b0;
        fill_inc    = 1'b0;
        miss_inc    = 1'b0;
        op_we_hash  = 1'b0;
        op_we_key   = 1'b0;
        op_clr_hash = 1'b0;
        unique case (r_cur_op)
            hdmsc_pkg::OP_TEST: begin
                op_hit = !slot_empty && hash_eq && key_eq;
            end
            hdmsc_pkg::OP_INSERT: begin
                fill_inc   = slot_empty;
                op_we_hash = 1'b1;
                op_we_key  = 1'b1;
            end
            hdmsc_pkg::OP_REMOVE: begin
                op_we_hash  = 1'b1;
                op_clr_hash = 1'b1;
            end
            hdmsc_pkg::OP_TRY_INSERT: begin
                op_hit     = slot_empty;
                fill_inc   = slot_empty;
                op_we_hash = slot_empty;
            end
            hdmsc_pkg::OP_TEST_INS: begin
                if (hash_eq && key_eq) begin
                    op_hit = 1'b1;
                end else begin
                    op_we_hash = 1'b1;
                    op_we_key  = 1'b1;
                    fill_inc   = slot_empty;
                    miss_inc   = !slot_empty;
                end
            end
            default: begin
            end
        endcase
    end

    // state machine outputs
    always_comb begin
        exec_go = (r_state == hdmsc_pkg::ST_EXEC) && out_free;
        o_q_pop = (r_state == hdmsc_pkg::ST_IDLE) && !i_q_empty;
        o_clearing = (r_state == hdmsc_pkg::ST_CLEAR);
        if (o_clearing) begin
            we_hash = 1'b1;
            we_key  = 1'b1;
            waddr   = r_clr_idx;
            wd_hash = '0;
            wd_key  = '0;
        end else begin
            we_hash = exec_go && op_we_hash;
            we_key  = exec_go && op_we_key;
            waddr   = cur_idx;
            wd_hash = op_clr_hash ? '0 : r_cur_hash;
            wd_key  = r_cur_key;
        end
    end

    always_comb begin
        n_clr_idx   = o_clearing ? r_clr_idx + INDEX_BITS'(1) : r_clr_idx;
        n_fill      = r_fill;
        n_miss      = r_miss;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && i_out_stall;
        if (exec_go) begin
            n_out_valid = 1'b1;
            n_hit       = op_hit;
            // counters saturate at all ones
            if (fill_inc && r_fill != '1) begin
                n_fill = r_fill + CNT_W'(1);
            end
            if (miss_inc && r_miss != '1) begin
                n_miss = r_miss + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hdmsc_pkg::ST_CLEAR;
            r_clr_idx   <= '0;
            r_fill      <= '0;
            r_miss      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_fill      <= n_fill;
            r_miss      <= n_miss;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= n_hit;
        if (o_q_pop) begin
            r_cur_op   <= hdmsc_pkg::t_op'(i_q_data[ENTRY_W-1 -: hdmsc_pkg::OP_W]);
            r_cur_hash <= i_q_data[KEY_WIDTH +: HASH_W];
            r_cur_key  <= i_q_data[KEY_WIDTH-1:0];
        end
    end

    // slot memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we_hash) begin
            r_mem_hash[waddr] <= wd_hash;
        end
        if (we_key) begin
            r_mem_key[waddr] <= wd_key;
        end
        r_rd_hash <= r_mem_hash[cur_idx];
        r_rd_key  <= r_mem_key[cur_idx];
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_hit;
    assign o_slots_used = r_fill;
    assign o_miss_count = r_miss;

endmodule

>>> design/hashed_direct_mapped_state_cache_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_direct_mapped_state_cache_core
// Direct-mapped hash table, indexed by the low hash bits, with test, insert,
// remove, try-insert and test-and-insert requests and two saturating counters.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot memory to empty, one slot per cycle,
// over all 2^INDEX_BITS slots, holding o_in_stall high the whole time. After
// that each transaction passes through the table side as queue pop, memory
// read, then compute and write back, set by the read-then-write sequence on
// the single slot memory, so the table side takes no new transaction until
// the last one is written back. A two-entry queue takes new requests while a
// result waits on a stalled output; o_slots_used and o_miss_count show the
// counters as they stand after the transaction on the output.
module hashed_direct_mapped_state_cache_core #(
    parameter int INDEX_BITS = hdmsc_pkg::INDEX_BITS_DEF,
    parameter int KEY_WIDTH  = hdmsc_pkg::KEY_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [hdmsc_pkg::ACT_W-1:0]  i_action,
    input  logic [hdmsc_pkg::HASH_W-1:0] i_hash_value,
    input  logic [KEY_WIDTH-1:0]         i_element_key,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_hit,
    output logic [hdmsc_pkg::CNT_W-1:0]  o_slots_used,
    output logic [hdmsc_pkg::CNT_W-1:0]  o_miss_count
);

    localparam int ENTRY_W = hdmsc_pkg::OP_W + hdmsc_pkg::HASH_W + KEY_WIDTH;

    logic [ENTRY_W-1:0] entry;
    logic [ENTRY_W-1:0] q_data;
    logic               q_full, q_empty, q_pop, clearing;
    logic               push;

    assign o_in_stall = q_full || clearing;
    assign push       = i_in_valid && !o_in_stall;

    hdmsc_front #(
        .KEY_WIDTH (KEY_WIDTH),
        .ENTRY_W   (ENTRY_W)
    ) u_front (
        .i_action      (i_action),
        .i_hash_value  (i_hash_value),
        .i_element_key (i_element_key),
        .o_entry       (entry)
    );

    hdmsc_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (entry),
        .i_pop       (q_pop),
        .o_pop_data  (q_data),
        .o_full      (q_full),
        .o_empty     (q_empty)
    );

    hdmsc_back #(
        .INDEX_BITS (INDEX_BITS),
        .KEY_WIDTH  (KEY_WIDTH),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_data     (q_data),
        .o_q_pop      (q_pop),
        .o_clearing   (clearing),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_hit        (o_hit),
        .o_slots_used (o_slots_used),
        .o_miss_count (o_miss_count)
    );

endmodule

>>> design/hdmsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdmsc_checker
// Port-level checks on the cache core: result holding, counter behavior and
// the post-reset sweep.
// ----------------------------------------------------------------------------
module hdmsc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_stall,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        o_hit,
    input logic [hdmsc_pkg::CNT_W-1:0] o_slots_used,
    input logic [hdmsc_pkg::CNT_W-1:0] o_miss_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_hit) && $stable(o_slots_used) && $stable(o_miss_count))
        else $error("result changed while stalled");

    // fill count moves only with a new transaction on the output, by one
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (o_slots_used != $past(o_slots_used)) |->
            o_out_valid && (o_slots_used == $past(o_slots_used) + hdmsc_pkg::CNT_W'(1)))
        else $error("slots_used stepped wrongly");

    a_miss_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (o_miss_count != $past(o_miss_count)) |->
            o_out_valid && (o_miss_count == $past(o_miss_count) + hdmsc_pkg::CNT_W'(1)))
        else $error("miss_count stepped wrongly");

    // on leaving reset the block is in the table sweep: input stalled, output empty
    a_sweep: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_in_stall && !o_out_valid &&
            (o_slots_used == '0) && (o_miss_count == '0))
        else $error("block not in sweep after reset");

endmodule

bind hashed_direct_mapped_state_cache_core hdmsc_checker u_hdmsc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_stall  (i_out_stall),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .o_hit        (o_hit),
    .o_slots_used (o_slots_used),
    .o_miss_count (o_miss_count)
);

>>> bench/tb_hashed_direct_mapped_state_cache_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_direct_mapped_state_cache_core
// Drives requests into the direct-mapped hash cache and checks every result.
// A local copy of the slot table and both counters predicts hit, slots used
// and miss count for each accepted request. Directed requests come first,
// then random traffic on a small set of colliding hashes. Random idling on
// both sides and one long output hold-off fill the block and stall its input.
// ----------------------------------------------------------------------------
module tb_hashed_direct_mapped_state_cache_core;

    localparam int IDX_W        = hdmsc_pkg::INDEX_BITS_DEF;
    localparam int KEY_W        = hdmsc_pkg::KEY_WIDTH_DEF;
    localparam int ACT_W        = hdmsc_pkg::ACT_W;
    localparam int HASH_W       = hdmsc_pkg::HASH_W;
    localparam int CNT_W        = hdmsc_pkg::CNT_W;
    localparam int SLOTS        = 1 << IDX_W;
    localparam int POOL_SIZE    = 24;
    localparam int SLOT_PICKS   = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 300000;

    // action codes the block treats as no-ops
    localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_C = 3'd7;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] slots_used;
        logic [CNT_W-1:0] miss_count;
    } t_cache_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [ACT_W-1:0]  i_action;
    logic [HASH_W-1:0] i_hash_value;
    logic [KEY_W-1:0]  i_element_key;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_hit;
    logic [CNT_W-1:0]  o_slots_used;
    logic [CNT_W-1:0]  o_miss_count;

    // local copy of the table and counters
    logic [HASH_W-1:0] table_hash [SLOTS];
    logic [KEY_W-1:0]  table_key  [SLOTS];
    logic [CNT_W-1:0]  fill_count;
    logic [CNT_W-1:0]  overwrite_count;

    t_cache_result     pending_results [$];
    logic [HASH_W-1:0] hash_pool [POOL_SIZE];
    logic [KEY_W-1:0]  key_pool  [POOL_SIZE];

    int  send_idle_pct;
    int  stall_pct;
    int  hold_left;
    bit  hold_request;
    int  error_count;
    int  cycle_count;

    hashed_direct_mapped_state_cache_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_hash_value  (i_hash_value),
        .i_element_key (i_element_key),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit         (o_hit),
        .o_slots_used  (o_slots_used),
        .o_miss_count  (o_miss_count)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL hashed_direct_mapped_state_cache_core");
            $finish;
        end
    end

    // output stall: random, or held high for a counted stretch on request
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    // applies one request to the local table and returns the result it causes
    function automatic t_cache_result predict_lookup(input logic [ACT_W-1:0]  act,
                                                     input logic [HASH_W-1:0] h,
                                                     input logic [KEY_W-1:0]  k);
        logic [IDX_W-1:0]  idx;
        logic [HASH_W-1:0] old;
        logic              key_eq;
        t_cache_result     res;
        idx    = h[IDX_W-1:0];
        old    = table_hash[idx];
        key_eq = (table_key[idx] == k);
        res.hit = 1'b0;
        case (act)
            hdmsc_pkg::ACT_TEST: begin
                res.hit = (old != '0) && (old == h) && key_eq;
            end
            hdmsc_pkg::ACT_INSERT: begin
                if (old == '0) fill_count = sat_inc(fill_count);
                table_hash[idx] = h;
                table_key[idx]  = k;
            end
            hdmsc_pkg::ACT_REMOVE: begin
                table_hash[idx] = '0;
            end
            hdmsc_pkg::ACT_TRY_INSERT: begin
                // claims the hash only, the old key stays in the slot
                if (old == '0) begin
                    table_hash[idx] = h;
                    fill_count = sat_inc(fill_count);
                    res.hit = 1'b1;
                end
            end
            hdmsc_pkg::ACT_TEST_INS: begin
                if (old == h && key_eq) begin
                    res.hit = 1'b1;
                end else begin
                    if (old == '0) fill_count = sat_inc(fill_count);
                    else overwrite_count = sat_inc(overwrite_count);
                    table_hash[idx] = h;
                    table_key[idx]  = k;
                end
            end
            default: ;
        endcase
        res.slots_used = fill_count;
        res.miss_count = overwrite_count;
        return res;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_cache_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction hit=%0b slots_used=%0d miss_count=%0d",
                         $time, o_hit, o_slots_used, o_miss_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_hit !== want.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, o_hit);
                    error_count++;
                end
                if (o_slots_used !== want.slots_used) begin
                    $display("%0t: slots_used expected %0d actual %0d",
                             $time, want.slots_used, o_slots_used);
                    error_count++;
                end
                if (o_miss_count !== want.miss_count) begin
                    $display("%0t: miss_count expected %0d actual %0d",
                             $time, want.miss_count, o_miss_count);
                    error_count++;
                end
            end
        end
    end

    task automatic send_request(input logic [ACT_W-1:0]  act,
                                input logic [HASH_W-1:0] h,
                                input logic [KEY_W-1:0]  k);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_hash_value  <= h;
        i_element_key <= k;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(predict_lookup(act, h, k));
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // many hashes on a few slots so hits, claims and overwrites all happen
    task automatic refill_pool();
        logic [IDX_W-1:0] slot_pick [SLOT_PICKS];
        logic [HASH_W-1:0] h;
        foreach (slot_pick[i]) slot_pick[i] = IDX_W'($urandom_range(SLOTS - 1));
        for (int j = 0; j < POOL_SIZE; j++) begin
            h = {$urandom, $urandom};
            h[IDX_W-1:0] = slot_pick[$urandom_range(SLOT_PICKS - 1)];
            if (h == '0) h[IDX_W] = 1'b1;
            hash_pool[j] = h;
            key_pool[j]  = {$urandom, $urandom};
        end
    endtask

    task automatic send_random_request(input bit well_formed_only);
        logic [ACT_W-1:0]  act;
        logic [HASH_W-1:0] h;
        logic [KEY_W-1:0]  k;
        int j;
        int r;
        if (well_formed_only || $urandom_range(99) < 85) begin
            j = $urandom_range(POOL_SIZE - 1);
            h = hash_pool[j];
            k = ($urandom_range(99) < 80) ? key_pool[j] : key_pool[$urandom_range(POOL_SIZE - 1)];
            r = $urandom_range(99);
            if (r < 25)      act = hdmsc_pkg::ACT_TEST;
            else if (r < 45) act = hdmsc_pkg::ACT_INSERT;
            else if (r < 55) act = hdmsc_pkg::ACT_REMOVE;
            else if (r < 70) act = hdmsc_pkg::ACT_TRY_INSERT;
            else             act = hdmsc_pkg::ACT_TEST_INS;
        end else begin
            // noise: any code, any hash including the empty mark, any key
            act = ACT_W'($urandom_range(7));
            h   = ($urandom_range(19) == 0) ? '0 : {$urandom, $urandom};
            k   = {$urandom, $urandom};
        end
        send_request(act, h, k);
    endtask

    task automatic test_directed_actions();
        logic [HASH_W-1:0] h_a;
        logic [HASH_W-1:0] h_b;
        logic [KEY_W-1:0]  k_a;
        h_a = '1;
        h_b = {1'b0, {(HASH_W - 1){1'b1}}};
        k_a = '1;
        send_request(hdmsc_pkg::ACT_TEST,       h_a, k_a);
        send_request(hdmsc_pkg::ACT_INSERT,     h_a, k_a);
        send_request(hdmsc_pkg::ACT_TEST,       h_a, k_a);
        send_request(hdmsc_pkg::ACT_TEST,       h_a, '0);
        send_request(hdmsc_pkg::ACT_TEST,       h_b, k_a);
        send_request(hdmsc_pkg::ACT_TRY_INSERT, h_b, '0);
        send_request(hdmsc_pkg::ACT_TEST_INS,   h_a, k_a);
        send_request(hdmsc_pkg::ACT_TEST_INS,   h_b, '0);
        send_request(hdmsc_pkg::ACT_REMOVE,     h_b, '0);
        send_request(hdmsc_pkg::ACT_TEST,       h_b, '0);
        send_request(hdmsc_pkg::ACT_TRY_INSERT, h_a, k_a);
        send_request(hdmsc_pkg::ACT_TEST,       h_a, '0);
        send_request(hdmsc_pkg::ACT_INSERT,     h_a, k_a);
        send_request(hdmsc_pkg::ACT_INSERT,     64'd1, '0);
    endtask

    task automatic test_zero_hash_and_unused_codes();
        send_request(ACT_SPARE_A,               '1, '1);
        send_request(ACT_SPARE_B,               '0, '0);
        send_request(ACT_SPARE_C,               64'd1, '1);
        send_request(hdmsc_pkg::ACT_TEST,       '0, '0);
        send_request(hdmsc_pkg::ACT_TEST_INS,   '0, '0);
        send_request(hdmsc_pkg::ACT_TEST_INS,   '0, '1);
        send_request(hdmsc_pkg::ACT_INSERT,     '0, 64'h5555_5555_5555_5555);
        send_request(hdmsc_pkg::ACT_TRY_INSERT, '0, '0);
        send_request(hdmsc_pkg::ACT_REMOVE,     64'd1, '0);
    endtask

    task automatic test_random_traffic(input int count, input int src_pct, input int dst_pct);
        send_idle_pct = src_pct;
        stall_pct     = dst_pct;
        refill_pool();
        repeat (count) send_random_request(1'b0);
        wait_for_results();
    endtask

    task automatic test_backpressure_fill();
        send_idle_pct = 0;
        stall_pct     = 30;
        refill_pool();
        hold_request  = 1'b1;
        repeat (30) send_random_request(1'b1);
        wait_for_results();
    endtask

    initial begin
        error_count   = 0;
        cycle_count   = 0;
        hold_left     = 0;
        hold_request  = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        fill_count      = '0;
        overwrite_count = '0;
        foreach (table_hash[i]) begin
            table_hash[i] = '0;
            table_key[i]  = '0;
        end
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_action      <= hdmsc_pkg::ACT_TEST;
        i_hash_value  <= '0;
        i_element_key <= '0;
        i_out_stall   <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 20;
        stall_pct     = 20;
        test_directed_actions();
        test_zero_hash_and_unused_codes();
        wait_for_results();

        test_random_traffic(240, 34, 83);
        test_random_traffic(240, 83, 34);
        test_random_traffic(220, 0, 0);
        test_backpressure_fill();

        wait_for_results();
        if (error_count == 0) begin
            $display("PASS hashed_direct_mapped_state_cache_core");
        end else begin
            $display("FAIL hashed_direct_mapped_state_cache_core");
        end
        $finish;
    end

endmodule
